[rtl/led_blink_code_status_assert.svh]
// ----------------------------------------------------------------------------
// led_blink_code_status_assert.svh
// Assertion macros shared by the blink code status checker.
// ----------------------------------------------------------------------------
`ifndef LED_BLINK_CODE_STATUS_ASSERT_SVH
`define LED_BLINK_CODE_STATUS_ASSERT_SVH

// Same-cycle implication, muted while reset is high.
`define LBCS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lbcs assertion failed");

// Next-cycle implication, muted while reset is high.
`define LBCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lbcs assertion failed");

`endif

[rtl/lbcs_pkg.sv]
// ----------------------------------------------------------------------------
// lbcs_pkg
// Types and constants of the blink code status lamp.
// ----------------------------------------------------------------------------
package lbcs_pkg;

   localparam int TICK_W = 32;
   localparam int TIME_W = 16;
   localparam int POT_W  = 12;
   localparam int POS_W  = 2;
   localparam int CNT_W  = 3;
   localparam int IDX_W  = 3;

   // register indexes
   localparam logic [IDX_W-1:0] CSR_CORNER   = 3'd0;
   localparam logic [IDX_W-1:0] CSR_ON       = 3'd1;
   localparam logic [IDX_W-1:0] CSR_OFF      = 3'd2;
   localparam logic [IDX_W-1:0] CSR_GAP      = 3'd3;
   localparam logic [IDX_W-1:0] CSR_POT_LOW  = 3'd4;
   localparam logic [IDX_W-1:0] CSR_POT_HIGH = 3'd5;

   // reset values
   localparam logic [POS_W-1:0]  CORNER_RST   = 2'd0;
   localparam logic [TIME_W-1:0] ON_RST       = 16'd150;
   localparam logic [TIME_W-1:0] OFF_RST      = 16'd150;
   localparam logic [TIME_W-1:0] GAP_RST      = 16'd700;
   localparam logic [POT_W-1:0]  POT_LOW_RST  = 12'd10;
   localparam logic [POT_W-1:0]  POT_HIGH_RST = 12'd4085;

   localparam logic [CNT_W-1:0]  CNT_MAX      = 3'd7;

   typedef struct packed {
      logic [TICK_W-1:0] now_tick;
      logic              gauge_seen;
      logic [POT_W-1:0]  pot_sample;
   } req_payload_type;

   typedef struct packed {
      logic blink_pin;
      logic gauge_pin;
      logic pot_pin;
   } rsp_payload_type;

   typedef struct packed {
      logic [POS_W-1:0]  corner_position;
      logic [TIME_W-1:0] on_ticks;
      logic [TIME_W-1:0] off_ticks;
      logic [TIME_W-1:0] gap_ticks;
      logic [POT_W-1:0]  pot_low_limit;
      logic [POT_W-1:0]  pot_high_limit;
   } cfg_type;

   typedef enum logic [2:0] {
      PH_INIT = 3'b001,
      PH_DARK = 3'b010,
      PH_LIT  = 3'b100
   } phase_type;

endpackage

[rtl/led_blink_code_status.sv]
// ----------------------------------------------------------------------------
// led_blink_code_status
// Blink code status lamp with gauge and pot status pins.
// ----------------------------------------------------------------------------
// Each req beat is one service call: tick time, gauge flag and pot sample.
// Each call gives exactly one rsp beat: the lamp level after the call and two
// active-low status pins. The lamp blinks corner_position+1 times per group,
// lit for on_ticks, dark for off_ticks between blinks and gap_ticks after a
// group; elapsed time is a wrapping 32-bit difference. The first call after
// reset only records the time and leaves the lamp dark. A call passes the
// input register, then the result register; one call is taken every cycle
// while rsp_ready is high. The rate is set by the lamp sequencer, which
// updates its state once per call. With rsp_ready high, req_ready stays high.
// Write the csr registers only while no call is in flight.
// ----------------------------------------------------------------------------
module led_blink_code_status
   import lbcs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // call channel
   input  logic              req_valid,
   output logic              req_ready,
   input  req_payload_type   req_data,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_payload_type   rsp_data,
   // configuration
   input  logic              csr_we,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [TIME_W-1:0] csr_wdata
);

   cfg_type         cfg;

   // input register
   logic            in_valid_ff, in_valid_in;
   req_payload_type in_data_ff;

   // result register
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_data_ff, out_data_in;

   logic            advance;   // input register beat moves to result register
   logic            lit_next;
   logic            in_window;

   lbcs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // lamp state advances exactly once per call, when the call moves on
   lbcs_lamp u_lamp (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .now_tick (in_data_ff.now_tick),
      .cfg      (cfg),
      .lit_next (lit_next)
   );

   // result register frees up when empty or when its beat is taken
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // an empty window (low above high) never matches
   assign in_window = (in_data_ff.pot_sample >= cfg.pot_low_limit) &&
                      (in_data_ff.pot_sample <= cfg.pot_high_limit);

   always_comb begin
      out_data_in.blink_pin = lit_next;
      out_data_in.gauge_pin = !in_data_ff.gauge_seen;
      out_data_in.pot_pin   = !in_window;
   end

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

[rtl/lbcs_csr.sv]
// ----------------------------------------------------------------------------
// lbcs_csr
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module lbcs_csr
   import lbcs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [TIME_W-1:0] csr_wdata,
   output cfg_type           cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CORNER:   cfg_in.corner_position = csr_wdata[POS_W-1:0];
            CSR_ON:       cfg_in.on_ticks        = csr_wdata;
            CSR_OFF:      cfg_in.off_ticks       = csr_wdata;
            CSR_GAP:      cfg_in.gap_ticks       = csr_wdata;
            CSR_POT_LOW:  cfg_in.pot_low_limit   = csr_wdata[POT_W-1:0];
            CSR_POT_HIGH: cfg_in.pot_high_limit  = csr_wdata[POT_W-1:0];
            default:      cfg_in = cfg_ff;  // unknown index: dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.corner_position <= CORNER_RST;
         cfg_ff.on_ticks        <= ON_RST;
         cfg_ff.off_ticks       <= OFF_RST;
         cfg_ff.gap_ticks       <= GAP_RST;
         cfg_ff.pot_low_limit   <= POT_LOW_RST;
         cfg_ff.pot_high_limit  <= POT_HIGH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/lbcs_lamp.sv]
// ----------------------------------------------------------------------------
// lbcs_lamp
// Blink sequencer: lamp phase, blink count and last change time.
// ----------------------------------------------------------------------------
module lbcs_lamp
   import lbcs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [TICK_W-1:0] now_tick,
   input  cfg_type           cfg,
   output logic              lit_next
);

   phase_type         phase_ff,  phase_in;
   logic [CNT_W-1:0]  blinks_ff, blinks_in;
   logic [TICK_W-1:0] last_ff,   last_in;

   logic [TICK_W-1:0] elapsed;
   logic [CNT_W-1:0]  target;
   logic              group_done;
   logic [TIME_W-1:0] wait_ticks;

   assign elapsed    = now_tick - last_ff;  // wraps modulo 2^TICK_W
   assign target     = {1'b0, cfg.corner_position} + CNT_W'(1);
   assign group_done = (blinks_ff >= target);
   assign wait_ticks = group_done ? cfg.gap_ticks : cfg.off_ticks;

   always_comb begin
      phase_in  = phase_ff;
      blinks_in = blinks_ff;
      last_in   = last_ff;
      unique case (phase_ff)
         PH_INIT: begin
            // first call only records the time
            phase_in = PH_DARK;
            last_in  = now_tick;
         end
         PH_LIT: begin
            if (elapsed >= {{(TICK_W-TIME_W){1'b0}}, cfg.on_ticks}) begin
               phase_in = PH_DARK;
               if (blinks_ff != CNT_MAX) begin
                  blinks_in = blinks_ff + CNT_W'(1);
               end
               last_in = now_tick;
            end
         end
         PH_DARK: begin
            if (elapsed >= {{(TICK_W-TIME_W){1'b0}}, wait_ticks}) begin
               if (group_done) begin
                  blinks_in = '0;
               end
               phase_in = PH_LIT;
               last_in  = now_tick;
            end
         end
         default: begin
            phase_in = PH_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_INIT;
         blinks_ff <= '0;
         last_ff   <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         blinks_ff <= blinks_in;
         last_ff   <= last_in;
      end
   end

   assign lit_next = (phase_in == PH_LIT);

endmodule

[rtl/lbcs_checker.sv]
// ----------------------------------------------------------------------------
// lbcs_checker
// Port-level checks of the blink code status lamp.
// ----------------------------------------------------------------------------
`include "led_blink_code_status_assert.svh"

module lbcs_checker
   import lbcs_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input req_payload_type   req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input rsp_payload_type   rsp_data
);

   logic seen_rsp_ff, seen_rsp_in;

   assign seen_rsp_in = seen_rsp_ff || (rsp_valid && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_rsp_ff <= 1'b0;
      end else begin
         seen_rsp_ff <= seen_rsp_in;
      end
   end

   // stalled result beat holds
   `LBCS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // stalled call beat holds
   `LBCS_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && !req_ready, req_valid && $stable(req_data))

   // nothing comes out right after reset
   `LBCS_ASSERT_IMPLY(a_rsp_clear, clock, reset, $past(reset), !rsp_valid)

   // a free result side never blocks calls
   `LBCS_ASSERT_IMPLY(a_req_free, clock, reset, !rsp_valid || rsp_ready, req_ready)

   // first result after reset keeps the lamp dark
   `LBCS_ASSERT_IMPLY(a_first_dark, clock, reset, rsp_valid && !seen_rsp_ff, !rsp_data.blink_pin)

endmodule

bind led_blink_code_status lbcs_checker u_lbcs_checker (.*);
